@@ hw/rtl/skr_pkg.sv @@
// Shared types and constants for the k-smallest tracker.
// No dependencies; imported by the cell, the top level and the testbench.
package skr_pkg;

    localparam int K_MAX = 16;
    localparam int CNT_W = $clog2(K_MAX + 1);
    localparam int VAL_W = 32;
    localparam int K_W   = 5;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REPLACE,
        OP_SHIFT
    } skr_op_t;

    typedef struct packed {
        skr_op_t                  op;
        logic signed [VAL_W-1:0] sample;
    } skr_ctrl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    ge_ins;
        logic                    ge_rep;
    } skr_link_t;

endpackage

@@ hw/rtl/streaming_k_smallest_tracker.sv @@
// Channel   Dir  Payload
// s_*       in   tdata[31:0] sample_value, tlast end_of_set
// m_*       out  tdata[31:0] kept_value, tlast last_of_run, tuser[0] too_few
// cfg_*     in   cfg_wdata[4:0] k_count, written when cfg_we is high
//
// Ordinary values: one transfer per cycle unless a result awaits m_tready; every cell
// compares and shifts at once. Final value: one result per cycle while m_tready is high
// (count results shifted out of cell 0, no input taken), or one zero result with too_few.
// Reset clears the count and sets k_count to 1; no clearing pass is needed.
// Depends on skr_pkg and skr_cell.
module streaming_k_smallest_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,   // k_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // sample_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // kept_value
    output logic        m_tlast,
    output logic [0:0]  m_tuser      // too_few
);
    import skr_pkg::*;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [K_W-1:0]          k_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_data_reg;
    logic                    out_last_reg;
    logic                    out_few_reg;

    logic [CNT_W-1:0]        eff_k;
    logic [CNT_W-1:0]        count_next;
    logic                    accept;
    logic                    do_insert;
    logic                    do_replace;
    logic                    load_out;
    skr_ctrl_t               ctrl;
    skr_link_t               links [K_MAX];

    always_comb
    begin
        if (k_reg == '0)
            eff_k = CNT_W'(1);
        else if (int'(k_reg) > K_MAX)
            eff_k = CNT_W'(K_MAX);
        else
            eff_k = CNT_W'(k_reg);
    end

    assign s_tready   = (state_reg == ST_COLLECT) && (!out_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign do_insert  = count_reg < eff_k;
    assign do_replace = !do_insert && ($signed(s_tdata) < links[0].value);
    assign load_out   = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign count_next = do_insert ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        ctrl.sample = $signed(s_tdata);
        if (accept && do_insert)
            ctrl.op = OP_INSERT;
        else if (accept && do_replace)
            ctrl.op = OP_REPLACE;
        else if (load_out)
            ctrl.op = OP_SHIFT;
        else
            ctrl.op = OP_HOLD;
    end

    for (genvar i = 0; i < K_MAX; i++)
    begin : g_cell
        skr_link_t          prev_link;
        logic signed [31:0] next_value;
        logic               valid_next;

        if (i == 0)
        begin : g_head
            assign prev_link.value  = $signed(s_tdata);
            assign prev_link.ge_ins = 1'b1;
            assign prev_link.ge_rep = 1'b1;
        end
        else
        begin : g_body
            assign prev_link = links[i-1];
        end

        if (i == K_MAX - 1)
        begin : g_tail
            assign next_value = '0;
            assign valid_next = 1'b0;
        end
        else
        begin : g_mid
            assign next_value = links[i+1].value;
            assign valid_next = count_reg > CNT_W'(i + 1);
        end

        skr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid_self (count_reg > CNT_W'(i)),
            .valid_next (valid_next),
            .prev_link  (prev_link),
            .next_value (next_value),
            .link       (links[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            k_reg         <= K_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_COLLECT:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        if (s_tlast)
                        begin
                            if (count_next < eff_k)
                            begin
                                out_valid_reg <= 1'b1;
                                out_data_reg  <= '0;
                                out_last_reg  <= 1'b1;
                                out_few_reg   <= 1'b1;
                                count_reg     <= '0;
                            end
                            else
                                state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= links[0].value;
                        out_last_reg  <= (count_reg == CNT_W'(1));
                        out_few_reg   <= 1'b0;
                        count_reg     <= count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                            state_reg <= ST_COLLECT;
                    end
                end
                default:
                    state_reg <= ST_COLLECT;
            endcase
            if (cfg_we)
            begin
                k_reg     <= cfg_wdata;
                count_reg <= '0;
                state_reg <= ST_COLLECT;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_few_reg;

endmodule

@@ hw/rtl/skr_cell.sv @@
// One cell of the sorted insertion chain: holds one kept value.
// Depends on skr_pkg for the operation code and link structs.
module skr_cell (
    input  logic                      clk,
    input  skr_pkg::skr_ctrl_t        ctrl,
    input  logic                      valid_self,
    input  logic                      valid_next,
    input  skr_pkg::skr_link_t        prev_link,
    input  logic signed [31:0]        next_value,
    output skr_pkg::skr_link_t        link
);
    import skr_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    ge_ins;
    logic                    ge_rep;

    assign ge_ins = valid_self && (value_reg >= ctrl.sample);
    assign ge_rep = valid_next && (next_value >= ctrl.sample);

    always_comb
    begin
        case (ctrl.op)
            OP_INSERT:
            begin
                if (ge_ins)
                    value_next = value_reg;
                else if (prev_link.ge_ins)
                    value_next = ctrl.sample;
                else
                    value_next = prev_link.value;
            end
            OP_REPLACE:
            begin
                if (ge_rep)
                    value_next = next_value;
                else if (prev_link.ge_rep)
                    value_next = ctrl.sample;
                else
                    value_next = value_reg;
            end
            OP_SHIFT:
                value_next = next_value;
            default:
                value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value  = value_reg;
    assign link.ge_ins = ge_ins;
    assign link.ge_rep = ge_rep;

endmodule

@@ hw/rtl/skr_checker.sv @@
// Port-level checks for the k-smallest tracker, bound to the top level.
// Depends on streaming_k_smallest_tracker port names only.
module skr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    a_few_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 32'd0))
        else $error("too-few result not final or not zero");

    a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a run is being emitted");

endmodule

bind streaming_k_smallest_tracker skr_checker u_skr_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for streaming_k_smallest_tracker: streams signed samples in sets,
// predicts the kept-smallest results in-line and checks every output transfer.
// Depends on skr_pkg and the tracker RTL.
module testbench;
    import skr_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_SAMPLES = 400;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last_flag;
    } sample_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last_flag;
        logic             too_few;
    } kept_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [K_W-1:0]   cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tlast;
    logic [0:0]       m_tuser;

    sample_t          sample_q[$];
    kept_result_t     kept_results_q[$];

    logic signed [VAL_W-1:0] kept_vals [K_MAX];
    int               kept_n    = 0;
    logic [K_W-1:0]   k_setting = 5'd1;

    int               mismatches     = 0;
    int               samples_queued = 0;
    int               idle_cycles    = 0;
    int               tx_gap         = 0;
    int               tx_burst       = 0;
    int               hold_left      = 0;
    bit               hold_request   = 1'b0;
    bit               hold_done      = 1'b0;
    logic [5:0]       rx_phase       = '0;
    logic [7:0]       rx_mask        = 8'hFF;

    streaming_k_smallest_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int k_limit();
        if (k_setting == 0)
            return 1;
        if (k_setting > K_MAX)
            return K_MAX;
        return k_setting;
    endfunction

    task automatic place_sorted(input logic signed [VAL_W-1:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < kept_n && kept_vals[pos] >= v)
            pos++;
        for (i = kept_n; i > pos; i--)
            kept_vals[i] = kept_vals[i-1];
        kept_vals[pos] = v;
        kept_n++;
    endtask

    task automatic track_sample(input logic signed [VAL_W-1:0] v, input logic last_flag);
        kept_result_t r;
        int           lim;
        int           i;
        lim = k_limit();
        if (kept_n < lim)
            place_sorted(v);
        else if (kept_n > 0 && v < kept_vals[0])
        begin
            for (i = 1; i < kept_n; i++)
                kept_vals[i-1] = kept_vals[i];
            kept_n--;
            place_sorted(v);
        end
        if (last_flag)
        begin
            if (kept_n < lim)
            begin
                r.value     = '0;
                r.last_flag = 1'b1;
                r.too_few   = 1'b1;
                kept_results_q.insert(kept_results_q.size(), r);
            end
            else
            begin
                for (i = 0; i < kept_n; i++)
                begin
                    r.value     = kept_vals[i];
                    r.last_flag = (i == kept_n - 1);
                    r.too_few   = 1'b0;
                    kept_results_q.insert(kept_results_q.size(), r);
                end
            end
            kept_n = 0;
        end
    endtask

    task automatic report(input string msg);
        if (mismatches < 100)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_sample(input logic [VAL_W-1:0] v, input logic last_flag);
        sample_t s;
        s.value     = v;
        s.last_flag = last_flag;
        sample_q.insert(sample_q.size(), s);
        samples_queued++;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 16) - 8;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_random_set(input int len, input bit terminated);
        int i;
        for (i = 0; i < len; i++)
            push_sample(rand_value(), terminated && (i == len - 1));
    endtask

    task automatic write_k(input logic [K_W-1:0] k);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
        k_setting = k;
        kept_n    = 0;
    endtask

    task automatic settle();
        while (sample_q.size() != 0 || s_tvalid || kept_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : sender
        sample_t nxt;
        bit      offer;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            offer = 1'b0;
            if (tx_gap != 0)
                tx_gap--;
            else if (sample_q.size() != 0)
            begin
                nxt   = sample_q.pop_front();
                offer = 1'b1;
                if (tx_burst != 0)
                    tx_burst--;
                if (tx_burst == 0)
                begin
                    tx_burst = $urandom_range(1, 24);
                    tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            s_tvalid <= offer;
            if (offer)
            begin
                s_tdata <= nxt.value;
                s_tlast <= nxt.last_flag;
            end
        end
    end

    always @(posedge clk)
    begin : receiver
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_phase == 0)
                rx_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            m_tready <= rx_mask[rx_phase[2:0]];
            rx_phase++;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        kept_result_t exp_r;
        if (rst_n && s_tvalid && s_tready)
            track_sample(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (kept_results_q.size() == 0)
                report($sformatf("unexpected result value=%h last=%b too_few=%b",
                                 m_tdata, m_tlast, m_tuser[0]));
            else
            begin
                exp_r = kept_results_q.pop_front();
                if (m_tdata !== exp_r.value)
                    report($sformatf("value %h, expected %h", m_tdata, exp_r.value));
                if (m_tlast !== exp_r.last_flag)
                    report($sformatf("last %b, expected %b", m_tlast, exp_r.last_flag));
                if (m_tuser[0] !== exp_r.too_few)
                    report($sformatf("too_few %b, expected %b", m_tuser[0], exp_r.too_few));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [K_W-1:0] k_plan [6];
        int             phase;
        int             lim;
        int             len;
        k_plan = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd2, 5'd1};
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_sample(32'h7FFF_FFFF, 1'b1);
        settle();
        write_k(5'd4);
        push_sample(32'd3, 1'b0);
        push_sample(-32'sd3, 1'b1);
        push_sample(32'd5, 1'b0);
        push_sample(32'd5, 1'b0);
        push_sample(32'd7, 1'b0);
        push_sample(32'd5, 1'b0);
        push_sample(32'd5, 1'b0);
        push_sample(32'd5, 1'b1);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        settle();
        write_k(5'd0);
        push_sample(32'd9, 1'b0);
        push_sample(-32'sd9, 1'b1);

        phase = 0;
        while (samples_queued < TARGET_SAMPLES)
        begin
            settle();
            write_k(phase < 6 ? k_plan[phase] : K_W'($urandom_range(0, 31)));
            if (phase == 3)
                hold_request = 1'b1;
            repeat ($urandom_range(2, 5))
            begin
                lim = k_limit();
                if (lim > 1 && $urandom_range(0, 5) == 0)
                    len = $urandom_range(1, lim - 1);
                else
                    len = lim + $urandom_range(0, 12);
                queue_random_set(len, 1'b1);
            end
            if ($urandom_range(0, 4) == 0)
                queue_random_set($urandom_range(1, 6), 1'b0);
            phase++;
        end
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && kept_results_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/skr_pkg.sv
hw/rtl/skr_cell.sv
hw/rtl/streaming_k_smallest_tracker.sv
hw/rtl/skr_checker.sv
tb/sv/testbench.sv
